@@ src/lexicographic_shortest_path_defines.svh @@
// Assertion macros shared by the lexicographic shortest path RTL.
// Files that assert include this header; it depends on nothing else.
`ifndef LEXICOGRAPHIC_SHORTEST_PATH_DEFINES_SVH
`define LEXICOGRAPHIC_SHORTEST_PATH_DEFINES_SVH
`ifndef SYNTH
`define LSP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsp implication check failed");
`define LSP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsp next-cycle check failed");
`else
`define LSP_ASSERT_IMP(label, ante, cons)
`define LSP_ASSERT_NXT(label, ante, cons)
`endif
`endif

@@ src/lsp_pkg.sv @@
// Package of the lexicographic shortest path block: constants, payload structs,
// controller states, datapath commands and status. Depends on nothing.
`default_nettype none
package lsp_pkg;
  localparam int NODE_W = 6;
  localparam int FW_W = 16;
  localparam int DIST_W = 23;
  localparam logic [DIST_W-1:0] DIST_INF = 23'h7FFFFF;
  localparam int OUT_W = 22;
  localparam logic [OUT_W-1:0] OUT_MAX = 22'h3FFFFF;
  localparam int NCNT_W = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_NODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_NODE = 2'd2;
  localparam logic [NCNT_W-1:0] NODE_COUNT_RESET = 7'd64;
  localparam int DEF_MAX_NODES = 64;
  localparam int DEF_MAX_EDGES = 1024;
  localparam int DEF_WEIGHT_BITS = 16;

  typedef struct packed {
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
    logic [FW_W-1:0]   primary_weight;
    logic [FW_W-1:0]   secondary_weight;
    logic              last_edge;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] path_node;
    logic              reachable;
    logic [OUT_W-1:0]  primary_dist;
    logic [OUT_W-1:0]  secondary_total;
    logic              last_of_path;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_POP, S_POP_WT, S_CUR_WT, S_SCAN, S_EDGE_WT, S_RLX_A,
    S_DIR_B, S_RLX_B, S_FIN_RD, S_FIN_WT, S_PUSH, S_B_SCAN, S_B_EDGE_WT,
    S_B_TIGHT_A, S_B_DIR_B, S_B_TIGHT_B, S_EMIT_RD, S_EMIT_WT, S_NOREACH,
    S_EMIT_HOLD
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_INIT, OP_POP_RD, OP_POP_LD, OP_CUR_LD, OP_E_RD,
    OP_NB_A, OP_NB_B, OP_RELAX, OP_FIN_RD, OP_FIN_LD, OP_PUSH, OP_STEP,
    OP_EM_RD, OP_EM_LD, OP_NR_LD, OP_EM_NEXT, OP_DONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic bounds_ok;
    logic q_empty;
    logic idx_end;
    logic from_hit;
    logic to_hit;
    logic from_ok;
    logic to_ok;
    logic tight;
    logic rd_inf;
    logic at_start;
    logic push_stop;
    logic out_valid;
    logic out_taken;
    logic out_last;
  } status_t;
endpackage
`default_nettype wire

@@ src/lexicographic_shortest_path.sv @@
// Top level of the lexicographic shortest path block.
// Uses lsp_pkg, lsp_ctrl and lsp_datapath.
//
// Edges are taken one per cycle while idle and written to the edge memory. The
// edge marked last starts a queue-based search: for every node taken from the
// queue, each stored edge is read through the single edge memory read port, and
// an edge end that matches the node relaxes the other end if it is a valid node.
// The rebuild walks back from the end node, scanning the stored edges the same
// way, and each path node is sent and held until the receiver takes it. No new
// edge is taken until the last result of a run has been transferred.
`default_nettype none
module lexicographic_shortest_path
  import lsp_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int MAX_EDGES = DEF_MAX_EDGES,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);
  cmd_t    cmd;
  status_t st;

  lsp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_last(in_data.last_edge),
    .in_ready(in_ready), .st(st), .cmd(cmd)
  );

  lsp_datapath #(
    .MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES), .WEIGHT_BITS(WEIGHT_BITS)
  ) u_datapath (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .out_ready(out_ready),
    .out_data(out_data), .out_valid(out_valid), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata), .cmd(cmd), .st(st)
  );
endmodule
`default_nettype wire

@@ src/lsp_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none
module lsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

@@ src/lsp_datapath.sv @@
// Datapath: configuration registers, edge, distance, queue and path memories,
// counters and the result register. Uses lsp_pkg, lsp_ram and the macro header.
`default_nettype none
`include "lexicographic_shortest_path_defines.svh"
module lsp_datapath
  import lsp_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int MAX_EDGES = DEF_MAX_EDGES,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire in_item_t              in_data,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  output logic                       out_valid,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire cmd_t                  cmd,
  output status_t                    st
);
  localparam int NI_W = $clog2(MAX_NODES);
  localparam int QC_W = $clog2(MAX_NODES + 1);
  localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EC_W = $clog2(MAX_EDGES + 1);
  localparam int WU = (WEIGHT_BITS < FW_W) ? WEIGHT_BITS : FW_W;
  localparam int EDGE_W = 2 * NODE_W + 2 * WU;

  logic [NCNT_W-1:0] node_count_r, node_count_nxt;
  logic [NODE_W-1:0] start_r, start_nxt, end_r, end_nxt;
  logic [EC_W-1:0]   edge_total_r, edge_total_nxt, idx_r, idx_nxt;
  logic [NODE_W-1:0] cur_node_r, cur_node_nxt, nb_r, nb_nxt;
  logic [DIST_W-1:0] cur_p_r, cur_p_nxt, cur_s_r, cur_s_nxt;
  logic [NI_W-1:0]   q_head_r, q_head_nxt;
  logic [QC_W-1:0]   q_count_r, q_count_nxt;
  logic [MAX_NODES-1:0] flags_r, flags_nxt, dvalid_r, dvalid_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [QC_W-1:0]   path_len_r, path_len_nxt, em_k_r, em_k_nxt;
  logic [OUT_W-1:0]  res_p_r, res_p_nxt, res_s_r, res_s_nxt;
  out_item_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              e_we, e_re;
  logic [EA_W-1:0]   e_waddr, e_raddr;
  logic [EDGE_W-1:0] e_wdata, e_rdata;
  logic              d_we, d_re;
  logic [NI_W-1:0]   d_waddr, d_raddr;
  logic [2*DIST_W-1:0] d_wdata, d_rdata;
  logic              q_we, q_re;
  logic [NI_W-1:0]   q_waddr, q_raddr;
  logic [NODE_W-1:0] q_wdata, q_rdata;
  logic              p_we, p_re;
  logic [NI_W-1:0]   p_waddr, p_raddr;
  logic [NODE_W-1:0] p_wdata, p_rdata;

  logic [NCNT_W-1:0] n_eff;
  logic [NODE_W-1:0] e_from, e_to;
  logic [WU-1:0]     e_w1, e_w2;
  logic [DIST_W-1:0] rd_p, rd_s, np, ns;
  logic [DIST_W:0]   np_sum, ns_sum, t_p, t_s;
  logic              better, nb_ok, tight;
  logic [QC_W:0]     tail_sum;
  logic [NI_W-1:0]   tail, head_inc;
  logic [QC_W-1:0]   em_addr;

  lsp_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .re(e_re), .raddr(e_raddr), .rdata(e_rdata)
  );
  lsp_ram #(.WIDTH(2 * DIST_W), .DEPTH(MAX_NODES)) u_dist_ram (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .re(d_re), .raddr(d_raddr), .rdata(d_rdata)
  );
  lsp_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .re(q_re), .raddr(q_raddr), .rdata(q_rdata)
  );
  lsp_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_path_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .re(p_re), .raddr(p_raddr), .rdata(p_rdata)
  );

  always_comb begin
    n_eff = (node_count_r > NCNT_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES) : node_count_r;
    e_from = e_rdata[EDGE_W-1 -: NODE_W];
    e_to = e_rdata[EDGE_W-NODE_W-1 -: NODE_W];
    e_w1 = e_rdata[2*WU-1 -: WU];
    e_w2 = e_rdata[WU-1:0];
    rd_p = rd_vld_r ? d_rdata[2*DIST_W-1 -: DIST_W] : DIST_INF;
    rd_s = rd_vld_r ? d_rdata[DIST_W-1:0] : DIST_INF;
    np_sum = {1'b0, cur_p_r} + (DIST_W+1)'(e_w1);
    ns_sum = {1'b0, cur_s_r} + (DIST_W+1)'(e_w2);
    np = (np_sum >= {1'b0, DIST_INF}) ? DIST_INF - 1'b1 : np_sum[DIST_W-1:0];
    ns = (ns_sum >= {1'b0, DIST_INF}) ? DIST_INF - 1'b1 : ns_sum[DIST_W-1:0];
    better = (np < rd_p) || ((np == rd_p) && (ns < rd_s));
    nb_ok = {1'b0, nb_r} < n_eff;
    t_p = {1'b0, rd_p} + (DIST_W+1)'(e_w1);
    t_s = {1'b0, rd_s} + (DIST_W+1)'(e_w2);
    tight = nb_ok && (rd_p != DIST_INF) && (t_p == {1'b0, cur_p_r}) &&
            (t_s == {1'b0, cur_s_r});
    tail_sum = (QC_W+1)'(q_head_r) + (QC_W+1)'(q_count_r);
    tail = (tail_sum >= (QC_W+1)'(MAX_NODES)) ?
           NI_W'(tail_sum - (QC_W+1)'(MAX_NODES)) : NI_W'(tail_sum);
    head_inc = (q_head_r == NI_W'(MAX_NODES - 1)) ? '0 : q_head_r + 1'b1;
    em_addr = path_len_r - 1'b1 - em_k_r;
  end

  always_comb begin
    node_count_nxt = node_count_r;
    start_nxt = start_r;
    end_nxt = end_r;
    edge_total_nxt = edge_total_r;
    idx_nxt = idx_r;
    cur_node_nxt = cur_node_r;
    cur_p_nxt = cur_p_r;
    cur_s_nxt = cur_s_r;
    nb_nxt = nb_r;
    q_head_nxt = q_head_r;
    q_count_nxt = q_count_r;
    flags_nxt = flags_r;
    dvalid_nxt = dvalid_r;
    rd_vld_nxt = rd_vld_r;
    path_len_nxt = path_len_r;
    em_k_nxt = em_k_r;
    res_p_nxt = res_p_r;
    res_s_nxt = res_s_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r;
    e_we = 1'b0;
    e_waddr = edge_total_r[EA_W-1:0];
    e_wdata = {in_data.from_node, in_data.to_node,
               in_data.primary_weight[WU-1:0], in_data.secondary_weight[WU-1:0]};
    e_re = 1'b0;
    e_raddr = idx_r[EA_W-1:0];
    d_we = 1'b0;
    d_waddr = nb_r[NI_W-1:0];
    d_wdata = {np, ns};
    d_re = 1'b0;
    d_raddr = e_to[NI_W-1:0];
    q_we = 1'b0;
    q_waddr = tail;
    q_wdata = nb_r;
    q_re = 1'b0;
    q_raddr = q_head_r;
    p_we = 1'b0;
    p_waddr = path_len_r[NI_W-1:0];
    p_wdata = cur_node_r;
    p_re = 1'b0;
    p_raddr = em_addr[NI_W-1:0];

    if (cfg_we) begin
      case (cfg_index)
        CFG_NODE_COUNT: node_count_nxt = cfg_wdata[NCNT_W-1:0];
        CFG_START_NODE: start_nxt = cfg_wdata[NODE_W-1:0];
        CFG_END_NODE:   end_nxt = cfg_wdata[NODE_W-1:0];
        default: ;
      endcase
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (cmd.op)
      OP_LOAD: begin
        if (edge_total_r < EC_W'(MAX_EDGES)) begin
          e_we = 1'b1;
          edge_total_nxt = edge_total_r + 1'b1;
        end
      end
      OP_INIT: begin
        dvalid_nxt = '0;
        dvalid_nxt[start_r[NI_W-1:0]] = 1'b1;
        d_we = 1'b1;
        d_waddr = start_r[NI_W-1:0];
        d_wdata = '0;
        q_we = 1'b1;
        q_waddr = '0;
        q_wdata = start_r;
        flags_nxt = '0;
        flags_nxt[start_r[NI_W-1:0]] = 1'b1;
        q_head_nxt = '0;
        q_count_nxt = QC_W'(1);
      end
      OP_POP_RD: begin
        q_re = 1'b1;
        q_head_nxt = head_inc;
        q_count_nxt = q_count_r - 1'b1;
      end
      OP_POP_LD: begin
        cur_node_nxt = q_rdata;
        flags_nxt[q_rdata[NI_W-1:0]] = 1'b0;
        d_re = 1'b1;
        d_raddr = q_rdata[NI_W-1:0];
        rd_vld_nxt = dvalid_r[q_rdata[NI_W-1:0]];
        idx_nxt = '0;
      end
      OP_CUR_LD: begin
        cur_p_nxt = rd_p;
        cur_s_nxt = rd_s;
      end
      OP_E_RD: begin
        e_re = 1'b1;
        idx_nxt = idx_r + 1'b1;
      end
      OP_NB_A: begin
        nb_nxt = e_to;
        d_re = 1'b1;
        d_raddr = e_to[NI_W-1:0];
        rd_vld_nxt = dvalid_r[e_to[NI_W-1:0]];
      end
      OP_NB_B: begin
        nb_nxt = e_from;
        d_re = 1'b1;
        d_raddr = e_from[NI_W-1:0];
        rd_vld_nxt = dvalid_r[e_from[NI_W-1:0]];
      end
      OP_RELAX: begin
        if (better) begin
          d_we = 1'b1;
          dvalid_nxt[nb_r[NI_W-1:0]] = 1'b1;
          if (!flags_r[nb_r[NI_W-1:0]] && (q_count_r < QC_W'(MAX_NODES))) begin
            q_we = 1'b1;
            q_count_nxt = q_count_r + 1'b1;
            flags_nxt[nb_r[NI_W-1:0]] = 1'b1;
          end
        end
      end
      OP_FIN_RD: begin
        d_re = 1'b1;
        d_raddr = end_r[NI_W-1:0];
        rd_vld_nxt = dvalid_r[end_r[NI_W-1:0]];
      end
      OP_FIN_LD: begin
        res_p_nxt = (rd_p > {1'b0, OUT_MAX}) ? OUT_MAX : rd_p[OUT_W-1:0];
        res_s_nxt = (rd_s > {1'b0, OUT_MAX}) ? OUT_MAX : rd_s[OUT_W-1:0];
        cur_node_nxt = end_r;
        cur_p_nxt = rd_p;
        cur_s_nxt = rd_s;
        path_len_nxt = '0;
      end
      OP_PUSH: begin
        p_we = 1'b1;
        path_len_nxt = path_len_r + 1'b1;
        idx_nxt = '0;
        em_k_nxt = '0;
      end
      OP_STEP: begin
        cur_node_nxt = nb_r;
        cur_p_nxt = rd_p;
        cur_s_nxt = rd_s;
      end
      OP_EM_RD: p_re = 1'b1;
      OP_EM_LD: begin
        out_nxt.path_node = p_rdata;
        out_nxt.reachable = 1'b1;
        out_nxt.primary_dist = res_p_r;
        out_nxt.secondary_total = res_s_r;
        out_nxt.last_of_path = (QC_W'(em_k_r + 1'b1) == path_len_r);
        out_valid_nxt = 1'b1;
      end
      OP_NR_LD: begin
        out_nxt.path_node = '0;
        out_nxt.reachable = 1'b0;
        out_nxt.primary_dist = '0;
        out_nxt.secondary_total = '0;
        out_nxt.last_of_path = 1'b1;
        out_valid_nxt = 1'b1;
      end
      OP_EM_NEXT: em_k_nxt = em_k_r + 1'b1;
      OP_DONE: edge_total_nxt = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RESET;
      start_r <= '0;
      end_r <= '0;
      edge_total_r <= '0;
      q_head_r <= '0;
      q_count_r <= '0;
      flags_r <= '0;
      dvalid_r <= '0;
      path_len_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      node_count_r <= node_count_nxt;
      start_r <= start_nxt;
      end_r <= end_nxt;
      edge_total_r <= edge_total_nxt;
      q_head_r <= q_head_nxt;
      q_count_r <= q_count_nxt;
      flags_r <= flags_nxt;
      dvalid_r <= dvalid_nxt;
      path_len_r <= path_len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    cur_node_r <= cur_node_nxt;
    cur_p_r <= cur_p_nxt;
    cur_s_r <= cur_s_nxt;
    nb_r <= nb_nxt;
    rd_vld_r <= rd_vld_nxt;
    em_k_r <= em_k_nxt;
    res_p_r <= res_p_nxt;
    res_s_r <= res_s_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    st.bounds_ok = ({1'b0, start_r} < n_eff) && ({1'b0, end_r} < n_eff);
    st.q_empty = (q_count_r == '0);
    st.idx_end = (idx_r == edge_total_r);
    st.from_hit = (e_from == cur_node_r);
    st.to_hit = (e_to == cur_node_r);
    st.from_ok = ({1'b0, e_from} < n_eff);
    st.to_ok = ({1'b0, e_to} < n_eff);
    st.tight = tight;
    st.rd_inf = (rd_p == DIST_INF);
    st.at_start = (cur_node_r == start_r);
    st.push_stop = (path_len_r >= QC_W'(MAX_NODES - 1));
    st.out_valid = out_valid_r;
    st.out_taken = out_valid_r && out_ready;
    st.out_last = out_r.last_of_path;
  end

  assign out_data = out_r;
  assign out_valid = out_valid_r;

  `LSP_ASSERT_IMP(a_qcount_max, 1'b1, q_count_r <= QC_W'(MAX_NODES))
  `LSP_ASSERT_IMP(a_pathlen_max, 1'b1, path_len_r <= QC_W'(MAX_NODES))
  `LSP_ASSERT_NXT(a_out_hold, out_valid_r && !out_ready, out_valid_r && $stable(out_r))
endmodule
`default_nettype wire

@@ src/lsp_ctrl.sv @@
// Controller state machine: sequences loading, relaxation, path rebuild and
// result transfers. Uses lsp_pkg and the macro header.
`default_nettype none
`include "lexicographic_shortest_path_defines.svh"
module lsp_ctrl
  import lsp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire logic    in_last,
  output logic         in_ready,
  input  wire status_t st,
  output cmd_t         cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op = OP_NONE;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_LOAD;
          if (in_last) begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        if (st.bounds_ok) begin
          cmd.op = OP_INIT;
          state_nxt = S_POP;
        end else begin
          state_nxt = S_NOREACH;
        end
      end
      S_POP: begin
        if (st.q_empty) begin
          state_nxt = S_FIN_RD;
        end else begin
          cmd.op = OP_POP_RD;
          state_nxt = S_POP_WT;
        end
      end
      S_POP_WT: begin
        cmd.op = OP_POP_LD;
        state_nxt = S_CUR_WT;
      end
      S_CUR_WT: begin
        cmd.op = OP_CUR_LD;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (st.idx_end) begin
          state_nxt = S_POP;
        end else begin
          cmd.op = OP_E_RD;
          state_nxt = S_EDGE_WT;
        end
      end
      S_EDGE_WT: begin
        if (st.from_hit && st.to_ok) begin
          cmd.op = OP_NB_A;
          state_nxt = S_RLX_A;
        end else begin
          state_nxt = S_DIR_B;
        end
      end
      S_RLX_A: begin
        cmd.op = OP_RELAX;
        state_nxt = S_DIR_B;
      end
      S_DIR_B: begin
        if (st.to_hit && st.from_ok) begin
          cmd.op = OP_NB_B;
          state_nxt = S_RLX_B;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_RLX_B: begin
        cmd.op = OP_RELAX;
        state_nxt = S_SCAN;
      end
      S_FIN_RD: begin
        cmd.op = OP_FIN_RD;
        state_nxt = S_FIN_WT;
      end
      S_FIN_WT: begin
        cmd.op = OP_FIN_LD;
        state_nxt = st.rd_inf ? S_NOREACH : S_PUSH;
      end
      S_PUSH: begin
        cmd.op = OP_PUSH;
        state_nxt = (st.at_start || st.push_stop) ? S_EMIT_RD : S_B_SCAN;
      end
      S_B_SCAN: begin
        if (st.idx_end) begin
          state_nxt = S_EMIT_RD;
        end else begin
          cmd.op = OP_E_RD;
          state_nxt = S_B_EDGE_WT;
        end
      end
      S_B_EDGE_WT: begin
        if (st.from_hit) begin
          cmd.op = OP_NB_A;
          state_nxt = S_B_TIGHT_A;
        end else begin
          state_nxt = S_B_DIR_B;
        end
      end
      S_B_TIGHT_A: begin
        if (st.tight) begin
          cmd.op = OP_STEP;
          state_nxt = S_PUSH;
        end else begin
          state_nxt = S_B_DIR_B;
        end
      end
      S_B_DIR_B: begin
        if (st.to_hit) begin
          cmd.op = OP_NB_B;
          state_nxt = S_B_TIGHT_B;
        end else begin
          state_nxt = S_B_SCAN;
        end
      end
      S_B_TIGHT_B: begin
        if (st.tight) begin
          cmd.op = OP_STEP;
          state_nxt = S_PUSH;
        end else begin
          state_nxt = S_B_SCAN;
        end
      end
      S_EMIT_RD: begin
        cmd.op = OP_EM_RD;
        state_nxt = S_EMIT_WT;
      end
      S_EMIT_WT: begin
        cmd.op = OP_EM_LD;
        state_nxt = S_EMIT_HOLD;
      end
      S_NOREACH: begin
        cmd.op = OP_NR_LD;
        state_nxt = S_EMIT_HOLD;
      end
      S_EMIT_HOLD: begin
        if (st.out_taken) begin
          if (st.out_last) begin
            cmd.op = OP_DONE;
            state_nxt = S_IDLE;
          end else begin
            cmd.op = OP_EM_NEXT;
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `LSP_ASSERT_IMP(a_out_only_hold, st.out_valid, state_r == S_EMIT_HOLD)
  `LSP_ASSERT_NXT(a_last_starts, (state_r == S_IDLE) && in_valid && in_last, state_r == S_INIT)
  `LSP_ASSERT_IMP(a_ready_idle, in_ready, state_r == S_IDLE)
endmodule
`default_nettype wire
